[rtl/core/bir_pkg.sv]
// ----------------------------------------------------------------------------
// bir_pkg
// shared widths, opcodes and reset value of the bitmap reservation block
// ----------------------------------------------------------------------------
package bir_pkg;

    localparam int OPCODE_W  = 2;
    localparam int START_W   = 20;
    localparam int END_W     = 21;
    localparam int IV_W      = 21;
    localparam int HORIZON_W = 20;

    // slot values in flight (start plus interval) stay below 2**23
    localparam int VAL_W = 23;

    localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_ONCE   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_REPEAT = 2'd2;

    localparam logic [HORIZON_W-1:0] HORIZON_RESET = 20'd1000000;

endpackage

[rtl/core/bir_if.sv]
// ----------------------------------------------------------------------------
// bir_if
// request and response channels of the bitmap reservation block
// ----------------------------------------------------------------------------
interface bir_req_if
    import bir_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [START_W-1:0]  start_req;
    logic [END_W-1:0]    end_req;
    logic [IV_W-1:0]     interval;

    modport source (output valid, output opcode, output start_req, output end_req,
                    output interval, input ready);
    modport sink   (input valid, input opcode, input start_req, input end_req,
                    input interval, output ready);
endinterface

interface bir_rsp_if;
    logic valid;
    logic ready;
    logic conflict;

    modport source (output valid, output conflict, input ready);
    modport sink   (input valid, input conflict, output ready);
endinterface

[rtl/core/bir_ram.sv]
// ----------------------------------------------------------------------------
// bir_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module bir_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16384
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                              wdata,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[rtl/core/bir_div.sv]
// ----------------------------------------------------------------------------
// bir_div
// split of a slot number into word index and bit offset by reciprocal
// multiply, two register stages
// ----------------------------------------------------------------------------
module bir_div
    import bir_pkg::*;
#(
    parameter int WORD_BITS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [VAL_W-1:0]              value,
    output logic                          done,
    output logic [VAL_W-1:0]              quo,
    output logic [$clog2(WORD_BITS)-1:0]  rem
);

    localparam int BIT_W  = $clog2(WORD_BITS);
    localparam int MUL_K  = VAL_W + BIT_W;
    localparam int RCP_W  = VAL_W + 2;
    localparam int PROD_W = VAL_W + RCP_W;
    localparam logic [RCP_W-1:0] RECIP =
        RCP_W'(((64'd1 << MUL_K) + 64'(WORD_BITS) - 64'd1) / 64'(WORD_BITS));
    localparam logic [VAL_W-1:0] DIVISOR = VAL_W'(WORD_BITS);

    logic [PROD_W-1:0] prod;
    logic [VAL_W-1:0]  q1_reg;
    logic [VAL_W-1:0]  v1_reg;
    logic              p1_reg;
    logic [VAL_W-1:0]  back;
    logic [VAL_W-1:0]  diff;
    logic [VAL_W-1:0]  quo_reg;
    logic [BIT_W-1:0]  rem_reg;
    logic              done_reg;

    assign prod = PROD_W'(value) * PROD_W'(RECIP);
    assign back = q1_reg * DIVISOR;
    assign diff = v1_reg - back;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            p1_reg   <= start;
            done_reg <= p1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        q1_reg  <= VAL_W'(prod[PROD_W-1:MUL_K]);
        v1_reg  <= value;
        quo_reg <= q1_reg;
        rem_reg <= diff[BIT_W-1:0];
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

[rtl/core/bitmap_interval_reservation_top.sv]
// ----------------------------------------------------------------------------
// bitmap_interval_reservation_top
// Keeps a one-bit-per-slot occupancy bitmap in a single-port ram of
// TIME_SLOTS/WORD_BITS words and a sticky conflict flag, and returns the flag
// for every request word. After reset the ram is swept to zero, one word a
// cycle with req.ready low. A clear runs the same sweep before its response.
// A reservation first splits start, end, interval and horizon+1 into word
// and bit with one two-stage reciprocal divider, then reads, checks and
// writes back each bitmap word that an occurrence touches, through the one
// ram port. Requests that change nothing (unused opcode, or a reservation
// while the flag is set) go straight to the response. One request is worked
// on at a time; a finished response waits in an output register while the
// next request is taken.
// ----------------------------------------------------------------------------
module bitmap_interval_reservation_top
    import bir_pkg::*;
#(
    parameter int TIME_SLOTS = 1048576,
    parameter int WORD_BITS  = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    bir_req_if.sink              req,
    bir_rsp_if.source            rsp,
    input  logic                 cfg_we,
    input  logic [HORIZON_W-1:0] cfg_data
);

    localparam int MAP_WORDS = (TIME_SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam logic [VAL_W-1:0]  TS_WORD   = VAL_W'(TIME_SLOTS / WORD_BITS);
    localparam logic [BIT_W-1:0]  TS_BIT    = BIT_W'(TIME_SLOTS % WORD_BITS);
    localparam logic [BIT_W-1:0]  BIT_MAX   = BIT_W'(WORD_BITS - 1);
    localparam logic [BIT_W:0]    BIT_WRAP  = (BIT_W + 1)'(WORD_BITS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAP_WORDS - 1);

    typedef enum logic [8:0] {
        S_SWEEP = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_DIV   = 9'b000000100,
        S_CLAMP = 9'b000001000,
        S_OCC   = 9'b000010000,
        S_READ  = 9'b000100000,
        S_CHECK = 9'b001000000,
        S_NEXT  = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [HORIZON_W-1:0] horizon_reg;
    logic                 conflict_reg, conflict_next;
    logic [ADDR_W-1:0]    clr_addr_reg, clr_addr_next;
    logic                 sweep_item_reg, sweep_item_next;
    logic [1:0]           div_sel_reg, div_sel_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_conflict_reg, out_conflict_next;

    logic [OPCODE_W-1:0]  op_reg;
    logic [END_W-1:0]     end_raw_reg;
    logic [IV_W-1:0]      iv_raw_reg;

    logic [VAL_W-1:0] s_w_reg, s_w_next, e_w_reg, e_w_next, iv_w_reg, iv_w_next;
    logic [BIT_W-1:0] s_b_reg, s_b_next, e_b_reg, e_b_next, iv_b_reg, iv_b_next;
    logic [VAL_W-1:0] lim_w_reg, lim_w_next, hz_w_reg, hz_w_next;
    logic [BIT_W-1:0] lim_b_reg, lim_b_next, hz_b_reg, hz_b_next;
    logic [VAL_W-1:0] last_w_reg, last_w_next, cur_w_reg, cur_w_next;
    logic [BIT_W-1:0] last_b_reg, last_b_next;

    logic                 div_start;
    logic [VAL_W-1:0]     div_value;
    logic                 div_done;
    logic [VAL_W-1:0]     div_quo;
    logic [BIT_W-1:0]     div_rem;
    logic [VAL_W-1:0]     dec_w;
    logic [BIT_W-1:0]     dec_b;

    logic                 s_lt_hz, e_gt_lim, e_gt_ts, s_lt_hi;
    logic [VAL_W-1:0]     hi_w, hi_dec_w;
    logic [BIT_W-1:0]     hi_b, hi_dec_b;

    logic [BIT_W-1:0]     lo_bit, hi_bit;
    logic [WORD_BITS-1:0] word_mask;
    logic                 hit;

    logic [BIT_W:0]       s_bsum, e_bsum;
    logic                 s_wrap, e_wrap;
    logic [BIT_W:0]       s_bdiff, e_bdiff;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_addr;
    logic [WORD_BITS-1:0] ram_wdata, ram_rdata;
    logic                 out_load;

    bir_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    bir_div #(
        .WORD_BITS (WORD_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .value (div_value),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    // operand for the next division
    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            div_value = VAL_W'(req.start_req);
        end
        else
        begin
            case (div_sel_reg)
                2'd0:    div_value = VAL_W'(end_raw_reg);
                2'd1:    div_value = VAL_W'(iv_raw_reg);
                default: div_value = VAL_W'(horizon_reg) + VAL_W'(1);
            endcase
        end
    end

    assign dec_w = (div_rem == '0) ? div_quo - VAL_W'(1) : div_quo;
    assign dec_b = (div_rem == '0) ? BIT_MAX : div_rem - BIT_W'(1);

    // word/bit comparisons
    assign s_lt_hz  = (s_w_reg < hz_w_reg) || ((s_w_reg == hz_w_reg) && (s_b_reg < hz_b_reg));
    assign e_gt_lim = (e_w_reg > lim_w_reg) || ((e_w_reg == lim_w_reg) && (e_b_reg > lim_b_reg));
    assign e_gt_ts  = (e_w_reg > TS_WORD) || ((e_w_reg == TS_WORD) && (e_b_reg > TS_BIT));
    assign hi_w     = e_gt_ts ? TS_WORD : e_w_reg;
    assign hi_b     = e_gt_ts ? TS_BIT : e_b_reg;
    assign s_lt_hi  = (s_w_reg < hi_w) || ((s_w_reg == hi_w) && (s_b_reg < hi_b));
    assign hi_dec_w = (hi_b == '0) ? hi_w - VAL_W'(1) : hi_w;
    assign hi_dec_b = (hi_b == '0) ? BIT_MAX : hi_b - BIT_W'(1);

    // bit span of the current word
    assign lo_bit    = (cur_w_reg == s_w_reg) ? s_b_reg : '0;
    assign hi_bit    = (cur_w_reg == last_w_reg) ? last_b_reg : BIT_MAX;
    assign word_mask = ({WORD_BITS{1'b1}} << lo_bit) & ({WORD_BITS{1'b1}} >> (BIT_MAX - hi_bit));
    assign hit       = |(ram_rdata & word_mask);

    // next occurrence
    assign s_bsum  = {1'b0, s_b_reg} + {1'b0, iv_b_reg};
    assign e_bsum  = {1'b0, e_b_reg} + {1'b0, iv_b_reg};
    assign s_wrap  = (s_bsum >= BIT_WRAP);
    assign e_wrap  = (e_bsum >= BIT_WRAP);
    assign s_bdiff = s_bsum - BIT_WRAP;
    assign e_bdiff = e_bsum - BIT_WRAP;

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        state_next        = state_reg;
        conflict_next     = conflict_reg;
        clr_addr_next     = clr_addr_reg;
        sweep_item_next   = sweep_item_reg;
        div_sel_next      = div_sel_reg;
        s_w_next          = s_w_reg;
        s_b_next          = s_b_reg;
        e_w_next          = e_w_reg;
        e_b_next          = e_b_reg;
        iv_w_next         = iv_w_reg;
        iv_b_next         = iv_b_reg;
        lim_w_next        = lim_w_reg;
        lim_b_next        = lim_b_reg;
        hz_w_next         = hz_w_reg;
        hz_b_next         = hz_b_reg;
        last_w_next       = last_w_reg;
        last_b_next       = last_b_reg;
        cur_w_next        = cur_w_reg;
        div_start         = 1'b0;
        ram_we            = 1'b0;
        ram_addr          = cur_w_reg[ADDR_W-1:0];
        ram_wdata         = ram_rdata | word_mask;
        out_valid_next    = out_valid_reg && !rsp.ready;
        out_conflict_next = out_conflict_reg;

        case (state_reg)
            S_SWEEP:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_addr_reg;
                ram_wdata = '0;
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = sweep_item_reg ? S_DONE : S_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + ADDR_W'(1);
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    case (req.opcode)
                        OP_CLEAR:
                        begin
                            conflict_next   = 1'b0;
                            clr_addr_next   = '0;
                            sweep_item_next = 1'b1;
                            state_next      = S_SWEEP;
                        end
                        OP_ONCE, OP_REPEAT:
                        begin
                            if (conflict_reg)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                div_start    = 1'b1;
                                div_sel_next = 2'd0;
                                state_next   = S_DIV;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    case (div_sel_reg)
                        2'd0:
                        begin
                            s_w_next     = div_quo;
                            s_b_next     = div_rem;
                            div_start    = 1'b1;
                            div_sel_next = 2'd1;
                        end
                        2'd1:
                        begin
                            e_w_next     = div_quo;
                            e_b_next     = div_rem;
                            div_start    = 1'b1;
                            div_sel_next = 2'd2;
                        end
                        2'd2:
                        begin
                            iv_w_next    = div_quo;
                            iv_b_next    = div_rem;
                            div_start    = 1'b1;
                            div_sel_next = 2'd3;
                        end
                        default:
                        begin
                            lim_w_next = div_quo;
                            lim_b_next = div_rem;
                            hz_w_next  = dec_w;
                            hz_b_next  = dec_b;
                            state_next = S_CLAMP;
                        end
                    endcase
                end
            end
            S_CLAMP:
            begin
                if ((op_reg == OP_REPEAT) && e_gt_lim)
                begin
                    e_w_next = lim_w_reg;
                    e_b_next = lim_b_reg;
                end
                state_next = S_OCC;
            end
            S_OCC:
            begin
                if ((op_reg == OP_REPEAT) && !s_lt_hz)
                begin
                    state_next = S_DONE;
                end
                else if (!s_lt_hi)
                begin
                    state_next = (op_reg == OP_REPEAT) ? S_NEXT : S_DONE;
                end
                else
                begin
                    last_w_next = hi_dec_w;
                    last_b_next = hi_dec_b;
                    cur_w_next  = s_w_reg;
                    state_next  = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (hit)
                begin
                    conflict_next = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    ram_we = 1'b1;
                    if (cur_w_reg == last_w_reg)
                    begin
                        state_next = (op_reg == OP_REPEAT) ? S_NEXT : S_DONE;
                    end
                    else
                    begin
                        cur_w_next = cur_w_reg + VAL_W'(1);
                        state_next = S_READ;
                    end
                end
            end
            S_NEXT:
            begin
                if (iv_raw_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    s_w_next   = s_w_reg + iv_w_reg + VAL_W'(s_wrap);
                    s_b_next   = s_wrap ? s_bdiff[BIT_W-1:0] : s_bsum[BIT_W-1:0];
                    e_w_next   = e_w_reg + iv_w_reg + VAL_W'(e_wrap);
                    e_b_next   = e_wrap ? e_bdiff[BIT_W-1:0] : e_bsum[BIT_W-1:0];
                    state_next = S_CLAMP;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next    = 1'b1;
                    out_conflict_next = conflict_reg;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_SWEEP;
            horizon_reg    <= HORIZON_RESET;
            conflict_reg   <= 1'b0;
            clr_addr_reg   <= '0;
            sweep_item_reg <= 1'b0;
            div_sel_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            conflict_reg   <= conflict_next;
            clr_addr_reg   <= clr_addr_next;
            sweep_item_reg <= sweep_item_next;
            div_sel_reg    <= div_sel_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                horizon_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            op_reg      <= req.opcode;
            end_raw_reg <= req.end_req;
            iv_raw_reg  <= req.interval;
        end
        out_conflict_reg <= out_conflict_next;
        s_w_reg          <= s_w_next;
        s_b_reg          <= s_b_next;
        e_w_reg          <= e_w_next;
        e_b_reg          <= e_b_next;
        iv_w_reg         <= iv_w_next;
        iv_b_reg         <= iv_b_next;
        lim_w_reg        <= lim_w_next;
        lim_b_reg        <= lim_b_next;
        hz_w_reg         <= hz_w_next;
        hz_b_reg         <= hz_b_next;
        last_w_reg       <= last_w_next;
        last_b_reg       <= last_b_next;
        cur_w_reg        <= cur_w_next;
    end

    assign req.ready    = (state_reg == S_IDLE);
    assign rsp.valid    = out_valid_reg;
    assign rsp.conflict = out_conflict_reg;

endmodule

[rtl/core/bir_checker.sv]
// ----------------------------------------------------------------------------
// bir_checker
// port-level checks of the bitmap reservation block, bound to the top level
// ----------------------------------------------------------------------------
module bir_checker
    import bir_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic [OPCODE_W-1:0] req_opcode,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic                rsp_conflict
);

    // a response word waiting for its sink holds still
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_conflict))
    else $error("response word changed while stalled");

    // one request word at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
    else $error("request taken while previous one in progress");

    // a clear sweeps the bitmap before the next request
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_opcode == OP_CLEAR) |-> ##2 !req_ready)
    else $error("clear finished without a sweep");

    // nothing is taken or shown once reset has been seen
    assert property (@(posedge clk)
        !rst_n |=> !req_ready && !rsp_valid)
    else $error("handshake active during reset");

endmodule

bind bitmap_interval_reservation_top bir_checker u_bir_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .req_opcode   (req.opcode),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_conflict (rsp.conflict)
);

[tb/sv/bitmap_interval_reservation_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bitmap_interval_reservation_top_tb
// Drives clear, one-shot, repeating and unused-opcode words into the block under
// several horizon settings, predicts the sticky conflict flag with its own
// copy of the occupancy bitmap, and compares every response word in order.
// Both channels stall in random bursts except in the closing phase.
// ----------------------------------------------------------------------------
module bitmap_interval_reservation_top_tb;
    import bir_pkg::*;

    localparam int unsigned SLOT_COUNT    = 1048576;
    localparam int unsigned MAP_WORD_BITS = 64;
    localparam int unsigned MAP_WORDS     = SLOT_COUNT / MAP_WORD_BITS;
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [HORIZON_W-1:0] cfg_data;

    bir_req_if req_bus ();
    bir_rsp_if rsp_bus ();

    bitmap_interval_reservation_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_bus),
        .rsp      (rsp_bus),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    logic [MAP_WORD_BITS-1:0] slot_words [MAP_WORDS];
    bit                       overlap_seen;
    logic [HORIZON_W-1:0]     horizon_reg;
    bit                       expected_flags [$];
    int                       error_count;
    bit                       tail_phase;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #60_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic bit claim_slots(longint unsigned lo, longint unsigned hi);
        longint unsigned first_w;
        longint unsigned last_w;
        longint unsigned a;
        longint unsigned b;
        logic [MAP_WORD_BITS-1:0] m;
        if (hi > SLOT_COUNT)
            hi = SLOT_COUNT;
        if (lo >= hi)
            return 1'b0;
        first_w = lo / MAP_WORD_BITS;
        last_w  = (hi - 1) / MAP_WORD_BITS;
        for (longint unsigned w = first_w; w <= last_w && w < MAP_WORDS; w++)
        begin
            a = (w == first_w) ? lo % MAP_WORD_BITS : 0;
            b = (w == last_w) ? (hi - 1) % MAP_WORD_BITS : MAP_WORD_BITS - 1;
            m = (b == MAP_WORD_BITS - 1) ? '1 : ((64'd1 << (b + 1)) - 64'd1);
            m = m & ~((64'd1 << a) - 64'd1);
            if ((slot_words[w] & m) != '0)
                return 1'b1;
            slot_words[w] = slot_words[w] | m;
        end
        return 1'b0;
    endfunction

    function automatic bit apply_request(logic [OPCODE_W-1:0] op, logic [START_W-1:0] s_in,
                                         logic [END_W-1:0] e_in, logic [IV_W-1:0] iv_in);
        longint unsigned s;
        longint unsigned e;
        longint unsigned iv;
        longint unsigned lim;
        s  = s_in;
        e  = e_in;
        iv = iv_in;
        case (op)
            OP_CLEAR:
            begin
                foreach (slot_words[i])
                    slot_words[i] = '0;
                overlap_seen = 1'b0;
            end
            OP_ONCE:
            begin
                if (!overlap_seen && claim_slots(s, e))
                    overlap_seen = 1'b1;
            end
            OP_REPEAT:
            begin
                if (!overlap_seen)
                begin
                    lim = longint'(horizon_reg) + 1;
                    if (e > lim)
                        e = lim;
                    while (s < horizon_reg)
                    begin
                        if (claim_slots(s, e))
                        begin
                            overlap_seen = 1'b1;
                            break;
                        end
                        if (iv == 0)
                            break;
                        s = s + iv;
                        e = e + iv;
                        if (e > lim)
                            e = lim;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return overlap_seen;
    endfunction

    task automatic send_word(input logic [OPCODE_W-1:0] op, input logic [START_W-1:0] s,
                             input logic [END_W-1:0] e, input logic [IV_W-1:0] iv);
        if (!tail_phase && $urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 7)) @(negedge clk);
        req_bus.valid     = 1'b1;
        req_bus.opcode    = op;
        req_bus.start_req = s;
        req_bus.end_req   = e;
        req_bus.interval  = iv;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        expected_flags.push_back(apply_request(op, s, e, iv));
        @(negedge clk);
        req_bus.valid = 1'b0;
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (expected_flags.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_horizon(input logic [HORIZON_W-1:0] value);
        wait_drained();
        cfg_we   = 1'b1;
        cfg_data = value;
        @(negedge clk);
        cfg_we      = 1'b0;
        horizon_reg = value;
    endtask

    task automatic test_one_shot_ranges();
        send_word(OP_ONCE, 0, 64, 0);
        send_word(OP_ONCE, 64, 65, 21'h1fffff);
        send_word(OP_ONCE, 20'hfffff, 21'h100000, 21'h100000);
        send_word(OP_ONCE, 524288, 524418, 0);
        send_word(OP_ONCE, 100, 100, 0);
        send_word(OP_ONCE, 300, 200, 0);
        send_word(OP_UNUSED, 20'hfffff, 21'h100000, 21'h100000);
    endtask

    task automatic test_sticky_flag();
        send_word(OP_ONCE, 63, 65, 0);
        send_word(OP_ONCE, 300000, 300010, 0);
        send_word(OP_REPEAT, 400000, 400005, 10);
        send_word(OP_UNUSED, 0, 0, 0);
        send_word(OP_CLEAR, 20'hfffff, 21'h100000, 21'h100000);
        send_word(OP_ONCE, 63, 65, 0);
        send_word(OP_ONCE, 300000, 300010, 0);
    endtask

    task automatic test_repeating_ranges();
        send_word(OP_REPEAT, 1000, 1010, 0);
        send_word(OP_ONCE, 1500, 1510, 0);
        send_word(OP_REPEAT, 10000, 10004, 100000);
        send_word(OP_ONCE, 910002, 910003, 0);
        send_word(OP_CLEAR, 0, 0, 0);
        send_word(OP_REPEAT, 2000, 2010, 5);
    endtask

    task automatic test_horizon_clamp();
        send_word(OP_CLEAR, 0, 0, 0);
        set_horizon(20'd0);
        send_word(OP_REPEAT, 0, 10, 5);
        send_word(OP_ONCE, 0, 10, 0);
        set_horizon(20'hfffff);
        send_word(OP_REPEAT, 1048560, 1048563, 4);
        send_word(OP_REPEAT, 5, 9, 21'h100000);
        send_word(OP_ONCE, 1048572, 1048575, 0);
        send_word(OP_CLEAR, 0, 0, 0);
        set_horizon(20'd5000);
        send_word(OP_REPEAT, 4990, 6000, 0);
        send_word(OP_ONCE, 5001, 5010, 0);
        send_word(OP_ONCE, 5000, 5001, 0);
        send_word(OP_CLEAR, 0, 0, 0);
    endtask

    task automatic test_random_traffic(input int count);
        int unsigned pick;
        int unsigned span;
        int unsigned n;
        int unsigned len;
        int unsigned s;
        int unsigned e;
        int unsigned iv;
        int unsigned prev_lo;
        int unsigned prev_len;
        prev_lo  = 0;
        prev_len = 0;
        for (int k = 0; k < count; k++)
        begin
            if (k == count / 2)
                wait_drained();
            pick = $urandom_range(0, 99);
            if (pick < 8)
                send_word(OP_CLEAR, START_W'($urandom), END_W'($urandom), IV_W'($urandom));
            else if (pick < 11)
                send_word(OP_UNUSED, START_W'($urandom), END_W'($urandom), IV_W'($urandom));
            else if (pick < 55)
            begin
                s    = $urandom_range(0, SLOT_COUNT - 1);
                len  = $urandom_range(1, 128);
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    len = $urandom_range(129, 4000);
                else if (pick == 1)
                    len = 0;
                else if (pick == 2 && prev_len != 0)
                    s = prev_lo + $urandom_range(0, prev_len - 1);
                e = (len == 0) ? $urandom_range(0, s) : s + len;
                if (e > SLOT_COUNT)
                    e = SLOT_COUNT;
                prev_lo  = s;
                prev_len = (e > s) ? e - s : 0;
                send_word(OP_ONCE, START_W'(s), END_W'(e), IV_W'($urandom));
            end
            else
            begin
                if (horizon_reg != 0 && $urandom_range(0, 9) < 7)
                    s = $urandom_range(0, horizon_reg);
                else
                    s = $urandom_range(0, SLOT_COUNT - 1);
                span = (horizon_reg > s) ? horizon_reg - s : 0;
                n    = $urandom_range(1, 24);
                pick = $urandom_range(0, 99);
                if (pick < 15)
                    iv = 0;
                else if (pick < 25)
                    iv = $urandom_range(span + 1, SLOT_COUNT);
                else
                    iv = span / n + 1;
                len = $urandom_range(1, (iv != 0 && iv < 100) ? iv : 100);
                if (iv != 0 && iv <= 5000 && $urandom_range(0, 5) == 0)
                    len = iv + $urandom_range(1, 10);
                e = s + len;
                if (e > SLOT_COUNT)
                    e = SLOT_COUNT;
                send_word(OP_REPEAT, START_W'(s), END_W'(e), IV_W'(iv));
            end
        end
    endtask

    // response ready with random stall bursts
    initial
    begin
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!tail_phase && $urandom_range(0, 9) == 0)
            begin
                rsp_bus.ready = 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge clk);
            end
            rsp_bus.ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (expected_flags.size() == 0)
            begin
                $error("conflict: expected none, actual %0d", rsp_bus.conflict);
                error_count++;
            end
            else
            begin
                if (rsp_bus.conflict !== expected_flags[0])
                begin
                    $error("conflict: expected %0d, actual %0d", expected_flags[0],
                           rsp_bus.conflict);
                    error_count++;
                end
                void'(expected_flags.pop_front());
            end
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_data          = '0;
        req_bus.valid     = 1'b0;
        req_bus.opcode    = OP_CLEAR;
        req_bus.start_req = '0;
        req_bus.end_req   = '0;
        req_bus.interval  = '0;
        error_count       = 0;
        tail_phase        = 1'b0;
        overlap_seen      = 1'b0;
        horizon_reg       = HORIZON_RESET;
        foreach (slot_words[i])
            slot_words[i] = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        test_one_shot_ranges();
        test_sticky_flag();
        test_repeating_ranges();
        test_horizon_clamp();

        set_horizon(HORIZON_RESET);
        test_random_traffic(12);
        set_horizon(HORIZON_W'($urandom_range(64, 20000)));
        test_random_traffic(12);
        set_horizon(20'hfffff);
        test_random_traffic(10);
        set_horizon(20'd0);
        test_random_traffic(8);
        set_horizon(HORIZON_W'($urandom));
        test_random_traffic(10);
        wait_drained();
        tail_phase = 1'b1;
        set_horizon(HORIZON_W'($urandom_range(1000, 100000)));
        test_random_traffic(15);

        wait_drained();
        repeat (100) @(posedge clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
